@@ design/joystick_axis_autocalibrator_core_assert.svh @@
`ifndef JOYSTICK_AXIS_AUTOCALIBRATOR_CORE_ASSERT_SVH
`define JOYSTICK_AXIS_AUTOCALIBRATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define JAAC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, sampled on clock, off during reset
`define JAAC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

@@ design/jaac_pkg.sv @@
package jaac_pkg;

   localparam int RAW_W       = 12;
   localparam int CFG_W       = 12;
   localparam int OUT_W       = 16;
   localparam int SPAN_W      = RAW_W + 1;
   localparam int SCALE_SHIFT = 16;
   localparam int DIVIDEND_W  = RAW_W + SCALE_SHIFT;
   localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CFG_W-1:0] CALIB_SPAN_RESET = CFG_W'(20);
   localparam logic [CFG_W-1:0] MIN_RANGE_RESET  = CFG_W'(10);

   localparam logic [DIVIDEND_W-1:0] POS_LIMIT = DIVIDEND_W'(2 ** (OUT_W - 1) - 1);
   localparam logic [DIVIDEND_W-1:0] NEG_LIMIT = DIVIDEND_W'(2 ** (OUT_W - 1));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [0:0] {
      REG_CALIB_SPAN = 1'b0,
      REG_MIN_RANGE  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic idle;
      logic update;
      logic prep;
      logic div_step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic req_fire;
      logic req_timed_out;
      logic div_last;
      logic out_busy;
   } dp_status_type;

endpackage

@@ design/jaac_req_if.sv @@
interface jaac_req_if;
   import jaac_pkg::*;

   logic             valid;
   logic             ready;
   logic             axis_select;
   logic [RAW_W-1:0] raw_count;
   logic             timed_out;

   modport source (output valid, output axis_select, output raw_count, output timed_out,
                   input ready);
   modport sink (input valid, input axis_select, input raw_count, input timed_out,
                 output ready);
endinterface

@@ design/jaac_rsp_if.sv @@
interface jaac_rsp_if;
   import jaac_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] axis_value;
   logic                    is_calibrated;

   modport source (output valid, output axis_value, output is_calibrated, input ready);
   modport sink (input valid, input axis_value, input is_calibrated, output ready);
endinterface

@@ design/jaac_ctrl.sv @@
module jaac_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  jaac_pkg::dp_status_type status,
   output jaac_pkg::dp_cmd_type    cmd
);
   import jaac_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_fire) begin
               state_in = status.req_timed_out ? ST_FINISH : ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.idle     = 1'b1;
         ST_UPDATE: cmd.update   = 1'b1;
         ST_PREP:   cmd.prep     = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_FINISH: cmd.finish   = !status.out_busy;
         default:   cmd          = '0;
      endcase
   end

endmodule

@@ design/jaac_datapath.sv @@
`include "joystick_axis_autocalibrator_core_assert.svh"

module jaac_datapath (
   input  logic                          clock,
   input  logic                          reset,
   jaac_req_if.sink                      req_chan,
   jaac_rsp_if.source                    rsp_chan,
   input  logic [jaac_pkg::CFG_W-1:0]    calib_span,
   input  logic [jaac_pkg::CFG_W-1:0]    min_range,
   input  jaac_pkg::dp_cmd_type          cmd,
   output jaac_pkg::dp_status_type       status
);
   import jaac_pkg::*;

   logic                  axis_ff;
   logic [RAW_W-1:0]      raw_ff;
   logic                  tout_ff;

   logic [RAW_W-1:0]      min_ff    [2];
   logic [RAW_W-1:0]      max_ff    [2];
   logic [RAW_W-1:0]      center_ff [2];
   logic                  flag_ff;

   logic [RAW_W-1:0]      range_ff;
   logic                  neg_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [RAW_W-1:0]      rem_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;

   logic                  rsp_valid_ff;
   logic [OUT_W-1:0]      rsp_value_ff;
   logic                  rsp_flag_ff;

   logic signed [SPAN_W-1:0] span0;
   logic signed [SPAN_W-1:0] span1;
   logic signed [SPAN_W-1:0] span_sel;
   logic signed [SPAN_W-1:0] calib_span_s;
   logic [CFG_W-1:0]         floor_val;
   logic [RAW_W-1:0]         range_in;
   logic signed [SPAN_W-1:0] centered;
   logic [RAW_W-1:0]         mag;
   logic [DIVIDEND_W-1:0]    dividend;
   logic [RAW_W:0]           trial;
   logic [RAW_W:0]           trial_sub;
   logic                     trial_ge;
   logic [OUT_W-1:0]         clamped;

   assign req_chan.ready = cmd.idle;

   assign status.req_fire      = req_chan.valid && cmd.idle;
   assign status.req_timed_out = req_chan.timed_out;
   assign status.div_last      = cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1);
   assign status.out_busy      = rsp_valid_ff && !rsp_chan.ready;

   assign span0        = $signed({1'b0, max_ff[0]}) - $signed({1'b0, min_ff[0]});
   assign span1        = $signed({1'b0, max_ff[1]}) - $signed({1'b0, min_ff[1]});
   assign span_sel     = axis_ff ? span1 : span0;
   assign calib_span_s = $signed({1'b0, calib_span});
   assign floor_val    = (min_range == '0) ? CFG_W'(1) : min_range;
   assign range_in     = (span_sel < $signed({1'b0, floor_val})) ? floor_val
                                                                  : span_sel[RAW_W-1:0];
   assign centered     = $signed({1'b0, raw_ff}) - $signed({1'b0, center_ff[axis_ff]});
   assign mag          = centered[SPAN_W-1] ? RAW_W'(-centered) : centered[RAW_W-1:0];
   // mag * 65535 == (mag << 16) - mag
   assign dividend     = {mag, SCALE_SHIFT'(0)} - DIVIDEND_W'(mag);

   assign trial     = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial_sub = trial - {1'b0, range_ff};
   assign trial_ge  = trial >= {1'b0, range_ff};

   always_comb begin
      if (neg_ff) begin
         clamped = (quo_ff > NEG_LIMIT) ? NEG_LIMIT[OUT_W-1:0]
                                        : (~quo_ff[OUT_W-1:0] + OUT_W'(1));
      end else begin
         clamped = (quo_ff > POS_LIMIT) ? POS_LIMIT[OUT_W-1:0] : quo_ff[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (status.req_fire) begin
         axis_ff <= req_chan.axis_select;
         raw_ff  <= req_chan.raw_count;
         tout_ff <= req_chan.timed_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            min_ff[i]    <= '1;
            max_ff[i]    <= '0;
            center_ff[i] <= '0;
         end
         flag_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            if (raw_ff < min_ff[axis_ff]) begin
               min_ff[axis_ff] <= raw_ff;
            end
            if (raw_ff > max_ff[axis_ff]) begin
               max_ff[axis_ff] <= raw_ff;
            end
            if (!flag_ff) begin
               center_ff[axis_ff] <= raw_ff;
            end
         end
         if (cmd.prep && ((span0 > calib_span_s) || (span1 > calib_span_s))) begin
            flag_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         range_ff <= range_in;
         neg_ff   <= centered[SPAN_W-1];
         quo_ff   <= dividend;
         rem_ff   <= '0;
         cnt_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? trial_sub[RAW_W-1:0] : trial[RAW_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], trial_ge};
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_value_ff <= tout_ff ? '0 : clamped;
         rsp_flag_ff  <= flag_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.axis_value    = $signed(rsp_value_ff);
   assign rsp_chan.is_calibrated = rsp_flag_ff;

   `JAAC_ASSERT_NEXT(a_flag_sticky, flag_ff, flag_ff)
   `JAAC_ASSERT_NOW(a_range_nonzero, cmd.div_step, range_ff != '0)
   `JAAC_ASSERT_NOW(a_rem_below_range, cmd.div_step, rem_ff < range_ff)
   `JAAC_ASSERT_NEXT(a_finish_loads_rsp, cmd.finish, rsp_valid_ff && rsp_flag_ff == $past(flag_ff))

endmodule

@@ design/joystick_axis_autocalibrator_core.sv @@
// Two-axis gameport calibrator. Each transfer on req_chan carries one raw pulse count
// for axis X or Y; each yields one transfer on rsp_chan with the signed position
// (raw - center) * 65535 / range, truncated toward zero and clamped to 16 bits, plus
// the calibrated flag. Timed-out samples return 0 and leave calibration state alone.
// A normal sample runs update, prepare, 28 steps of the restoring divider, output load
// and return to idle; a timed-out sample skips to output load. The result sits in an
// output register, so a new sample is accepted while it waits. Registers: calib_span
// at 0x0, min_range at 0x4; the user must write them only while idle (not enforced).
module joystick_axis_autocalibrator_core (
   input  logic                              clock,
   input  logic                              reset,
   jaac_req_if.sink                          req_chan,
   jaac_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [jaac_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [jaac_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [jaac_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import jaac_pkg::*;

   logic [CFG_W-1:0] calib_span_ff;
   logic [CFG_W-1:0] min_range_ff;
   csr_index_type    csr_index;
   dp_cmd_type       cmd;
   dp_status_type    status;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_span_ff <= CALIB_SPAN_RESET;
         min_range_ff  <= MIN_RANGE_RESET;
      end else if (psel && penable && pwrite && pready) begin
         case (csr_index)
            REG_CALIB_SPAN: calib_span_ff <= pwdata[CFG_W-1:0];
            REG_MIN_RANGE:  min_range_ff  <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CALIB_SPAN: prdata = CSR_DATA_W'(calib_span_ff);
         REG_MIN_RANGE:  prdata = CSR_DATA_W'(min_range_ff);
         default:        prdata = '0;
      endcase
   end

   jaac_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   jaac_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .calib_span (calib_span_ff),
      .min_range  (min_range_ff),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
